[rtl/core/ppt_pkg.sv]
package ppt_pkg;

    // stack geometry and index width
    localparam int STACK_ENTRIES = 32;
    localparam int INDEX_BITS    = 16;
    localparam int STACK_AW      = $clog2(STACK_ENTRIES);
    localparam int TOP_W         = $clog2(STACK_ENTRIES + 1);

    // fixed field widths
    localparam int DEPTH_W = 8;
    localparam int TAG_W   = 16;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 16;

    // debug tag codes that matter to the inside-function flag
    localparam logic [TAG_W-1:0] TAG_LEXICAL_BLOCK = 16'h000b;
    localparam logic [TAG_W-1:0] TAG_VARIABLE      = 16'h0034;
    localparam logic [TAG_W-1:0] TAG_SUBPROGRAM    = 16'h002e;
    localparam logic [TAG_W-1:0] TAG_INLINED       = 16'h001d;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_PAST_END = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TCLASS_CLEAR,
        TCLASS_SET,
        TCLASS_INHERIT
    } tag_class_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

    // one scope held on the stack
    typedef struct packed {
        logic [DEPTH_W-1:0]    depth;
        logic [INDEX_BITS-1:0] index;
        logic                  in_func;
    } scope_t;

    // classified entry handed from the front to the back
    typedef struct packed {
        logic [DEPTH_W-1:0]    depth;
        logic [INDEX_BITS-1:0] index;
        logic                  past_end;
        tag_class_t            tag_class;
    } job_t;

    function automatic tag_class_t classify_tag(input logic [TAG_W-1:0] tag);
        tag_class_t c;
        case (tag) inside
            TAG_LEXICAL_BLOCK, TAG_VARIABLE: c = TCLASS_INHERIT;
            TAG_SUBPROGRAM, TAG_INLINED:     c = TCLASS_SET;
            default:                         c = TCLASS_CLEAR;
        endcase
        return c;
    endfunction

    function automatic logic inside_flag(input tag_class_t c, input logic parent_valid,
                                         input logic parent_in_func);
        logic f;
        case (c)
            TCLASS_SET:     f = 1'b1;
            TCLASS_INHERIT: f = parent_valid & parent_in_func;
            default:        f = 1'b0;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/ppt_entry_if.sv]
interface ppt_entry_if
    import ppt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   tag;

    modport source (output valid, depth, tag, input ready);
    modport sink (input valid, depth, tag, output ready);
endinterface

[rtl/core/ppt_result_if.sv]
interface ppt_result_if
    import ppt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] entry_index;
    logic [FIELD_W-1:0] parent_index;
    logic               has_parent;
    logic               in_function;
    logic [1:0]         status;

    modport source (output valid, entry_index, parent_index, has_parent, in_function,
                    status, input ready);
    modport sink (input valid, entry_index, parent_index, has_parent, in_function,
                  status, output ready);
endinterface

[rtl/core/ppt_ram.sv]
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/ppt_front.sv]
module ppt_front
    import ppt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    ppt_entry_if.sink          entry,
    output job_t               job,
    output logic               job_valid,
    input  logic               job_ready
);

    logic [COUNT_W-1:0]    entry_count_reg;
    logic [INDEX_BITS-1:0] next_index_reg;
    logic [INDEX_BITS-1:0] next_index_next;
    logic                  accept;
    logic                  past_end;

    assign accept    = entry.valid && job_ready;
    assign past_end  = 32'(next_index_reg) >= 32'(entry_count_reg);

    // classify the entry and hand it on
    assign entry.ready   = job_ready;
    assign job_valid     = entry.valid;
    assign job.depth     = entry.depth;
    assign job.index     = next_index_reg;
    assign job.past_end  = past_end;
    assign job.tag_class = classify_tag(entry.tag);

    // running index only advances for entries inside the unit
    always_comb
    begin
        next_index_next = next_index_reg;
        if (accept && !past_end)
        begin
            next_index_next = next_index_reg + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            next_index_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entry_count_reg <= cfg_data;
            end
            next_index_reg <= next_index_next;
        end
    end

endmodule

[rtl/core/ppt_queue.sv]
module ppt_queue
    import ppt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t push_job,
    input  logic push_valid,
    output logic push_ready,
    output job_t pop_job,
    output logic pop_valid,
    input  logic pop_ready
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // two-slot fifo between front and back
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

[rtl/core/ppt_back.sv]
module ppt_back
    import ppt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_ready,
    ppt_result_if.source result
);

    back_state_t           state_reg, state_next;
    logic [TOP_W-1:0]      top_reg, top_next;
    scope_t                top_scope_reg, top_scope_next;
    scope_t                par_scope_reg, par_scope_next;
    logic                  par_from_ram_reg, par_from_ram_next;
    job_t                  job_reg, job_next;

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]    out_index_reg, out_index_next;
    logic [FIELD_W-1:0]    out_parent_reg, out_parent_next;
    logic                  out_has_reg, out_has_next;
    logic                  out_func_reg, out_func_next;
    status_t               out_status_reg, out_status_next;

    logic                  ram_we;
    logic [STACK_AW-1:0]   ram_waddr;
    scope_t                ram_wdata;
    logic                  ram_re;
    logic [STACK_AW-1:0]   ram_raddr;
    scope_t                ram_rdata;

    job_t                  cur_job;
    scope_t                par_eff;
    scope_t                new_scope;
    logic                  par_valid;
    logic                  out_free;
    logic                  pop_needed;
    logic                  do_pop;
    logic                  do_push;
    logic                  do_replace;
    logic                  do_past;
    logic [TOP_W-1:0]      top_m1;
    logic [TOP_W-1:0]      top_m3;

    // scopes above the sentinel; the top and its parent are also held in registers
    ppt_ram #(
        .WIDTH ($bits(scope_t)),
        .DEPTH (STACK_ENTRIES)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign top_m1     = top_reg - TOP_W'(1);
    assign top_m3     = top_reg - TOP_W'(3);
    assign out_free   = !out_valid_reg || result.ready;
    assign cur_job    = (state_reg == BK_IDLE) ? job : job_reg;
    assign par_eff    = par_from_ram_reg ? ram_rdata : par_scope_reg;
    assign par_valid  = top_reg > TOP_W'(1);
    assign pop_needed = (top_reg != '0) && (top_scope_reg.depth >= cur_job.depth);

    // pick the action for this cycle
    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        job_next   = job_reg;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        do_replace = 1'b0;
        do_past    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    job_ready = 1'b1;
                    if (job.past_end)
                    begin
                        do_past = 1'b1;
                    end
                    else if ((top_reg != '0) && (top_scope_reg.depth == job.depth))
                    begin
                        do_replace = 1'b1;
                    end
                    else if (pop_needed)
                    begin
                        do_pop     = 1'b1;
                        job_next   = job;
                        state_next = BK_POP;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
            end
            BK_POP:
            begin
                if (pop_needed)
                begin
                    do_pop = 1'b1;
                end
                else if (out_free)
                begin
                    do_push    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // stack update and result formation
    always_comb
    begin
        top_next          = top_reg;
        top_scope_next    = top_scope_reg;
        par_scope_next    = par_eff;
        par_from_ram_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = top_m1[STACK_AW-1:0];
        ram_re            = 1'b0;
        ram_raddr         = top_m3[STACK_AW-1:0];
        new_scope.depth   = cur_job.depth;
        new_scope.index   = cur_job.index;
        new_scope.in_func = 1'b0;
        ram_wdata         = new_scope;

        out_valid_next  = out_valid_reg && !result.ready;
        out_index_next  = out_index_reg;
        out_parent_next = out_parent_reg;
        out_has_next    = out_has_reg;
        out_func_next   = out_func_reg;
        out_status_next = out_status_reg;

        if (do_past)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = FIELD_W'(cur_job.index);
            out_parent_next = '0;
            out_has_next    = 1'b0;
            out_func_next   = 1'b0;
            out_status_next = STATUS_PAST_END;
        end

        // same depth: the new entry takes over the top scope
        if (do_replace)
        begin
            new_scope.in_func = inside_flag(cur_job.tag_class, par_valid, par_eff.in_func);
            ram_we            = 1'b1;
            ram_wdata         = new_scope;
            top_scope_next    = new_scope;
            out_valid_next    = 1'b1;
            out_index_next    = FIELD_W'(cur_job.index);
            out_parent_next   = par_valid ? FIELD_W'(par_eff.index) : '0;
            out_has_next      = par_valid;
            out_func_next     = new_scope.in_func;
            out_status_next   = STATUS_OK;
        end

        // drop the top scope, fetch the one below the new top as the new parent
        if (do_pop)
        begin
            top_next       = top_m1;
            top_scope_next = par_eff;
            if (top_reg > TOP_W'(2))
            begin
                ram_re            = 1'b1;
                par_from_ram_next = 1'b1;
            end
        end

        if (do_push)
        begin
            out_valid_next = 1'b1;
            out_index_next = FIELD_W'(cur_job.index);
            if (top_reg == TOP_W'(STACK_ENTRIES))
            begin
                // stack full: entry dropped, current top reported as parent
                out_parent_next = FIELD_W'(top_scope_reg.index);
                out_has_next    = 1'b1;
                out_func_next   = 1'b0;
                out_status_next = STATUS_OVERFLOW;
            end
            else
            begin
                new_scope.in_func = inside_flag(cur_job.tag_class, top_reg != '0,
                                                top_scope_reg.in_func);
                ram_we          = 1'b1;
                ram_waddr       = top_reg[STACK_AW-1:0];
                ram_wdata       = new_scope;
                top_next        = top_reg + TOP_W'(1);
                par_scope_next  = top_scope_reg;
                top_scope_next  = new_scope;
                out_parent_next = (top_reg != '0) ? FIELD_W'(top_scope_reg.index) : '0;
                out_has_next    = top_reg != '0;
                out_func_next   = new_scope.in_func;
                out_status_next = STATUS_OK;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            top_reg          <= '0;
            par_from_ram_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            top_reg          <= top_next;
            par_from_ram_reg <= par_from_ram_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        top_scope_reg  <= top_scope_next;
        par_scope_reg  <= par_scope_next;
        job_reg        <= job_next;
        out_index_reg  <= out_index_next;
        out_parent_reg <= out_parent_next;
        out_has_reg    <= out_has_next;
        out_func_reg   <= out_func_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.entry_index  = out_index_reg;
    assign result.parent_index = out_parent_reg;
    assign result.has_parent   = out_has_reg;
    assign result.in_function  = out_func_reg;
    assign result.status       = out_status_reg;

endmodule

[rtl/core/preorder_depth_parent_tracker.sv]
// Preorder parent tracker: takes tree entries (depth, tag) in preorder and returns one
// transaction per entry with its running index, its parent's index and an inside-function
// flag; status reports a full scope stack (entry dropped, index still used) or an entry
// beyond entry_count, which must be written while the block is idle. An entry at the
// same depth as the current top scope, or deeper, or beyond the count, is handled by the
// back end from its idle state; an entry that climbs out of k scopes takes one pop per
// scope and then the push, because each pop fetches the next parent from the scope
// stack memory, which has a registered read of one address a cycle. A two-entry queue
// between the classifying front end and the stack engine lets entries keep arriving while
// the stack unwinds; the back end takes a new entry only when the result register is
// empty or being taken in the same cycle, so a waiting result holds it. No clearing pass
// is needed after reset.
module preorder_depth_parent_tracker
    import ppt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    ppt_entry_if.sink          entry,
    ppt_result_if.source       result
);

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_ready;

    // index assignment and tag classification
    ppt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .entry     (entry),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    ppt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // scope stack engine
    ppt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .result    (result)
    );

endmodule

[tb/preorder_depth_parent_tracker_tb.sv]
`timescale 1ns / 100ps

module preorder_depth_parent_tracker_tb;
    import ppt_pkg::*;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [TAG_W-1:0]   tag;
    } tree_entry_t;

    typedef struct {
        logic [FIELD_W-1:0] entry_index;
        logic [FIELD_W-1:0] parent_index;
        logic               has_parent;
        logic               in_function;
        status_t            status;
    } entry_outcome_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    ppt_entry_if  entry_ch ();
    ppt_result_if result_ch ();

    preorder_depth_parent_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .entry    (entry_ch),
        .result   (result_ch)
    );

    // scope stack mirror, sentinel in slot zero
    int                    scope_depth [STACK_ENTRIES+1];
    logic [INDEX_BITS-1:0] scope_idx   [STACK_ENTRIES+1];
    logic                  scope_in    [STACK_ENTRIES+1];
    int                    scope_top;
    logic [INDEX_BITS-1:0] next_idx;
    logic [COUNT_W-1:0]    count_limit;

    tree_entry_t    pending_entries[$];
    entry_outcome_t expected_outcomes[$];
    tree_entry_t    send_item;
    entry_outcome_t want;
    int             err_count;
    bit             calm_stretch;
    int             walk_depth;

    // parent lookup for one accepted entry, updates the mirrored stack
    function automatic entry_outcome_t resolve_parent(input logic [DEPTH_W-1:0] d,
                                                      input logic [TAG_W-1:0] tag);
        entry_outcome_t o;
        logic [INDEX_BITS-1:0] cur;
        int up;
        logic flag;
        o.entry_index  = next_idx;
        o.parent_index = '0;
        o.has_parent   = 1'b0;
        o.in_function  = 1'b0;
        o.status       = STATUS_OK;
        if (next_idx >= count_limit)
        begin
            o.status = STATUS_PAST_END;
            return o;
        end
        cur      = next_idx;
        next_idx = next_idx + INDEX_BITS'(1);
        if (scope_depth[scope_top] == int'(d))
        begin
            scope_idx[scope_top] = cur;
        end
        else
        begin
            while (scope_top > 0 && scope_depth[scope_top] >= int'(d))
                scope_top--;
            // full stack: entry dropped, pops stay
            if (scope_top >= STACK_ENTRIES)
            begin
                o.status       = STATUS_OVERFLOW;
                o.parent_index = scope_idx[scope_top];
                o.has_parent   = 1'b1;
                return o;
            end
            scope_top++;
            scope_depth[scope_top] = int'(d);
            scope_idx[scope_top]   = cur;
        end
        up = scope_top - 1;
        if (tag == TAG_LEXICAL_BLOCK || tag == TAG_VARIABLE)
            flag = scope_in[up];
        else if (tag == TAG_SUBPROGRAM || tag == TAG_INLINED)
            flag = 1'b1;
        else
            flag = 1'b0;
        scope_in[scope_top] = flag;
        o.in_function       = flag;
        o.parent_index      = (up > 0) ? scope_idx[up] : '0;
        o.has_parent        = (up > 0);
        return o;
    endfunction

    // tags mostly from the scope-relevant set, the rest fully random
    function automatic logic [TAG_W-1:0] pick_tag();
        logic [TAG_W-1:0] t;
        if ($urandom_range(99) < 70)
        begin
            case ($urandom_range(3))
                0:       t = TAG_LEXICAL_BLOCK;
                1:       t = TAG_VARIABLE;
                2:       t = TAG_SUBPROGRAM;
                default: t = TAG_INLINED;
            endcase
        end
        else
        begin
            t = TAG_W'($urandom_range(65535));
        end
        return t;
    endfunction

    task automatic queue_entry(input int d, input logic [TAG_W-1:0] tag);
        tree_entry_t e;
        e.depth = DEPTH_W'(d);
        e.tag   = tag;
        pending_entries.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= v;
        count_limit = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // checked at the falling edge, once every clocked update has settled
    task automatic wait_drained();
        while (pending_entries.size() != 0 || entry_ch.valid || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    // clock and reset
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        entry_ch.valid   = 1'b0;
        entry_ch.depth   = '0;
        entry_ch.tag     = '0;
        result_ch.ready  = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (8) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // entry driver, prediction on each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            entry_ch.valid <= 1'b0;
        end
        else
        begin
            if (entry_ch.valid && entry_ch.ready)
                expected_outcomes.push_back(resolve_parent(entry_ch.depth, entry_ch.tag));
            if (!entry_ch.valid || entry_ch.ready)
            begin
                if (pending_entries.size() != 0
                    && (calm_stretch || $urandom_range(99) >= 10))
                begin
                    send_item = pending_entries.pop_front();
                    entry_ch.valid <= 1'b1;
                    entry_ch.depth <= send_item.depth;
                    entry_ch.tag   <= send_item.tag;
                end
                else
                begin
                    entry_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result transaction, entry_index %0d",
                           result_ch.entry_index);
                    err_count++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("entry_index", 32'(want.entry_index),
                                32'(result_ch.entry_index));
                    check_field("parent_index", 32'(want.parent_index),
                                32'(result_ch.parent_index));
                    check_field("has_parent", 32'(want.has_parent),
                                32'(result_ch.has_parent));
                    check_field("in_function", 32'(want.in_function),
                                32'(result_ch.in_function));
                    check_field("status", 32'(want.status), 32'(result_ch.status));
                end
            end
            result_ch.ready <= calm_stretch || ($urandom_range(99) >= 10);
        end
    end

    // stimulus phases
    initial
    begin
        int random_sent;
        int phase;
        int n;
        int made;
        int roll;
        int len;
        int lim;
        for (int i = 0; i <= STACK_ENTRIES; i++)
        begin
            scope_depth[i] = 0;
            scope_idx[i]   = '0;
            scope_in[i]    = 1'b0;
        end
        scope_depth[0] = -1;
        scope_top      = 0;
        next_idx       = '0;
        count_limit    = '0;
        err_count      = 0;
        calm_stretch   = 1'b0;
        walk_depth     = 0;
        random_sent    = 0;
        phase          = 0;

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // zero count: everything lands past the end
        write_entry_count('0);
        repeat (3) queue_entry($urandom_range(255), pick_tag());
        wait_drained();

        // directed walk through nesting, climbing, tag classes and extremes
        write_entry_count(16'hffff);
        queue_entry(0, TAG_SUBPROGRAM);
        queue_entry(1, TAG_LEXICAL_BLOCK);
        queue_entry(2, TAG_VARIABLE);
        queue_entry(2, TAG_INLINED);
        queue_entry(3, TAG_LEXICAL_BLOCK);
        queue_entry(4, 16'hffff);
        queue_entry(1, 16'h0000);
        queue_entry(2, TAG_LEXICAL_BLOCK);
        queue_entry(2, TAG_VARIABLE);
        queue_entry(0, 16'h0011);
        queue_entry(255, TAG_VARIABLE);
        queue_entry(255, TAG_SUBPROGRAM);
        queue_entry(128, TAG_LEXICAL_BLOCK);
        queue_entry(0, TAG_INLINED);
        queue_entry(127, 16'h8000);
        queue_entry(5, 16'h7fff);
        wait_drained();

        // random preorder walks, each phase ends with the pipeline drained
        while (random_sent < 900)
        begin
            n            = $urandom_range(60, 180);
            calm_stretch = (phase == 1);
            if (phase == 1)
                lim = int'(next_idx) + n / 2;
            else if ($urandom_range(3) == 0)
                lim = int'(next_idx) + $urandom_range(0, n);
            else
                lim = 65535;
            write_entry_count(COUNT_W'(lim));
            made = 0;
            // the first phase opens with a dive deep enough to overflow the stack
            if (phase == 0)
            begin
                for (int d = 0; d < 36; d++)
                    queue_entry(d, pick_tag());
                walk_depth = 35;
                made       = 36;
            end
            while (made < n)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                begin
                    len = $urandom_range(33, 40);
                    for (int d = 0; d < len; d++)
                        queue_entry(d, pick_tag());
                    walk_depth = len - 1;
                    made += len;
                end
                else
                begin
                    if (roll < 10)
                        walk_depth = $urandom_range(255);
                    else if (roll < 45)
                        walk_depth = (walk_depth < 255) ? walk_depth + 1 : 255;
                    else if (roll >= 70)
                        walk_depth = $urandom_range(0, walk_depth);
                    queue_entry(walk_depth, pick_tag());
                    made++;
                end
            end
            random_sent += made;
            wait_drained();
            calm_stretch = 1'b0;
            phase++;
        end

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop on a hung run
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
